// ----- hdl/rlps_pkg.sv -----
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types, constants and decode helpers for the RGB LED plane scanner.
// ----------------------------------------------------------------------------
package rlps_pkg;

   localparam int unsigned NUM_CH     = 3;
   localparam int unsigned PLANE_W    = 64;
   localparam int unsigned POS_W      = 6;
   localparam int unsigned BYTES_PER  = 8;

   localparam logic [4:0] KEY_MAX    = 5'd23;
   localparam logic [4:0] SEP_MAX    = 5'd22;
   localparam logic [4:0] DIRECT_MAX = 5'd15;
   localparam logic [5:0] KEY_BASE   = 6'd17;
   localparam logic [5:0] SEP_BASE   = 6'd18;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      CMD_KEY    = 2'd0,
      CMD_SEP    = 2'd1,
      CMD_DIRECT = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   // one LED update toward the plane store
   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] pos;
      logic [2:0]       rgb;   // bit 0 red, bit 1 green, bit 2 blue
   } led_wr_type;

   // colour code to rgb mask
   function automatic logic [2:0] rgb_of_code(input logic [2:0] code);
      logic [2:0] rgb;
      case (code)
         3'd0:    rgb = 3'd0;
         3'd1:    rgb = 3'd1;
         3'd2:    rgb = 3'd4;
         3'd3:    rgb = 3'd3;
         3'd4:    rgb = 3'd2;
         3'd5:    rgb = 3'd5;
         3'd6:    rgb = 3'd6;
         default: rgb = 3'd7;
      endcase
      return rgb;
   endfunction

   // group index to LED position plus an in-range flag
   function automatic led_wr_type led_decode(input cmd_type    cmd,
                                             input logic [4:0] idx,
                                             input logic [2:0] code);
      led_wr_type w;
      w.rgb = rgb_of_code(code);
      w.en  = 1'b0;
      w.pos = {1'b0, idx};
      case (cmd)
         CMD_KEY: begin
            w.en  = (idx <= KEY_MAX);
            w.pos = KEY_BASE + {idx, 1'b0};
         end
         CMD_SEP: begin
            w.en  = (idx <= SEP_MAX);
            w.pos = SEP_BASE + {idx, 1'b0};
         end
         CMD_DIRECT: begin
            w.en  = (idx <= DIRECT_MAX);
            w.pos = {1'b0, idx};
         end
         default: begin
            w.en  = 1'b0;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/rlps_planes.sv -----
// ----------------------------------------------------------------------------
// rlps_planes
// Three 64-bit colour planes; one LED update per cycle, one plane read out.
// ----------------------------------------------------------------------------
module rlps_planes (
   input  logic                  clock,
   input  logic                  reset,
   input  rlps_pkg::led_wr_type  led_wr,
   input  logic [1:0]            rd_ch,
   output logic [63:0]           rd_plane
);
   import rlps_pkg::*;

   logic [PLANE_W-1:0] plane_ff [NUM_CH];
   logic [PLANE_W-1:0] plane_in [NUM_CH];

   // position p sits at bit 63-p, so byte 0 is the top byte
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         plane_in[c] = plane_ff[c];
         if (led_wr.en) begin
            plane_in[c][6'(PLANE_W - 1) - led_wr.pos] = led_wr.rgb[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            plane_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < NUM_CH; c++) begin
            plane_ff[c] <= plane_in[c];
         end
      end
   end

   always_comb begin
      case (rd_ch)
         CH_RED:   rd_plane = plane_ff[0];
         CH_GREEN: rd_plane = plane_ff[1];
         default:  rd_plane = plane_ff[2];
      endcase
   end

endmodule

// ----- hdl/rlps_shifter.sv -----
// ----------------------------------------------------------------------------
// rlps_shifter
// Holds a plane snapshot and sends it out as eight bytes, top byte first.
// ----------------------------------------------------------------------------
module rlps_shifter (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,        // only when free is high
   input  logic [63:0] load_plane,
   input  logic [1:0]  load_ch,
   output logic        free,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_byte,
   output logic [1:0]  out_ch,
   output logic        out_last
);
   import rlps_pkg::*;

   logic               busy_ff, busy_in;
   logic [PLANE_W-1:0] data_ff, data_in;
   logic [1:0]         ch_ff, ch_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               take;

   assign take      = busy_ff && out_ready;
   assign out_last  = (cnt_ff == 3'(BYTES_PER - 1));
   assign free      = !busy_ff || (take && out_last);
   assign out_valid = busy_ff;
   assign out_byte  = data_ff[PLANE_W-1 -: 8];
   assign out_ch    = ch_ff;

   always_comb begin
      busy_in = busy_ff;
      data_in = data_ff;
      ch_in   = ch_ff;
      cnt_in  = cnt_ff;
      if (take) begin
         data_in = {data_ff[PLANE_W-9:0], 8'h00};
         cnt_in  = cnt_ff + 3'd1;
         if (out_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         data_in = load_plane;
         ch_in   = load_ch;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      ch_ff   <= ch_in;
   end

endmodule

// ----- hdl/rgb_led_plane_scanner_core.sv -----
// ----------------------------------------------------------------------------
// rgb_led_plane_scanner_core
// Bit-plane store and scan serializer for 64 multiplexed on/off RGB LEDs.
// ----------------------------------------------------------------------------
// A request word either sets one LED's colour (key, separator or direct
// group) or asks for a scan tick. Each request is registered, then handled
// in one pass: a colour write updates the red, green and blue planes
// together, so writes stream at one word per clock while no tick waits. An
// enabled tick snapshots the plane chosen by the scan phase (red, green,
// blue, repeat) into the output serializer, which sends eight response
// words, byte 0 first, one per cycle while rsp_tready is high; tlast marks
// the eighth byte (latch and channel enable). The serializer is the pacing
// unit: a tick that arrives while the previous one's bytes are still draining
// waits in the input register until the last byte is taken. A tick goes from
// the input register into the serializer register, which drives the first
// response byte. Ticks with scanning disabled are dropped and leave the phase
// alone. The plane store resets to all dark; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_led_plane_scanner_core (
   input  logic        clock,
   input  logic        reset,
   // configuration: scan_enable
   input  logic        csr_we,
   input  logic        csr_wdata,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] cmd, [6:2] led_index, [9:7] colour_code
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] shift_byte, [9:8] channel_select
   output logic        rsp_tlast    // last
);
   import rlps_pkg::*;

   // scan enable register
   logic scan_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_en_ff <= 1'b0;
      end else if (csr_we) begin
         scan_en_ff <= csr_wdata;
      end
   end

   // input register
   logic       stage_vld_ff, stage_vld_in;
   cmd_type    stage_cmd_ff;
   logic [4:0] stage_idx_ff;
   logic [2:0] stage_code_ff;
   logic       req_take;
   logic       stage_done;
   logic       tick_fire;
   logic       ser_free;

   assign req_take = req_tvalid && req_tready;

   // a tick needs the serializer; everything else retires at once
   assign tick_fire  = stage_vld_ff && (stage_cmd_ff == CMD_TICK) && scan_en_ff;
   assign stage_done = stage_vld_ff && (!tick_fire || ser_free);
   assign req_tready = !stage_vld_ff || stage_done;

   always_comb begin
      stage_vld_in = stage_vld_ff;
      if (stage_done) begin
         stage_vld_in = 1'b0;
      end
      if (req_take) begin
         stage_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_cmd_ff  <= cmd_type'(req_tdata[1:0]);
         stage_idx_ff  <= req_tdata[6:2];
         stage_code_ff <= req_tdata[9:7];
      end
   end

   // scan phase 0,1,2; a stray 3 reads as blue and wraps to 0
   logic [1:0] phase_ff, phase_in;
   logic [1:0] scan_ch;
   logic       tick_go;

   assign tick_go = tick_fire && ser_free;
   assign scan_ch = (phase_ff >= CH_BLUE) ? CH_BLUE : phase_ff;

   always_comb begin
      phase_in = phase_ff;
      if (tick_go) begin
         phase_in = (phase_ff >= CH_BLUE) ? CH_RED : phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= CH_RED;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // LED update from the staged word
   led_wr_type led_wr;
   led_wr_type led_dec;
   logic [63:0] cur_plane;

   always_comb begin
      led_dec   = led_decode(stage_cmd_ff, stage_idx_ff, stage_code_ff);
      led_wr    = led_dec;
      led_wr.en = led_dec.en && stage_vld_ff;
   end

   rlps_planes u_planes (
      .clock    (clock),
      .reset    (reset),
      .led_wr   (led_wr),
      .rd_ch    (scan_ch),
      .rd_plane (cur_plane)
   );

   // output serializer
   logic [7:0] out_byte;
   logic [1:0] out_ch;

   rlps_shifter u_shifter (
      .clock      (clock),
      .reset      (reset),
      .load       (tick_go),
      .load_plane (cur_plane),
      .load_ch    (scan_ch),
      .free       (ser_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (out_byte),
      .out_ch     (out_ch),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, out_ch, out_byte};

   // checks
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("scan phase left 0..2");

   a_tick_output: assert property (@(posedge clock) disable iff (reset)
      tick_go |=> rsp_tvalid && !rsp_tlast)
      else $error("tick did not start a byte burst");

   a_tick_no_write: assert property (@(posedge clock) disable iff (reset)
      tick_fire |-> !led_wr.en)
      else $error("plane write during a tick");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_ch != 2'd3)
      else $error("bad channel on response");

endmodule
